@@ hw/rtl/counting_bloom_ram_h3_assert.svh @@
// Assertion macros for the counting Bloom filter RAM node.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef COUNTING_BLOOM_RAM_H3_ASSERT_SVH
`define COUNTING_BLOOM_RAM_H3_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBRH3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBRH3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cbrh3_pkg.sv @@
// Package for the counting Bloom filter RAM node: default sizes, field widths
// and operation codes. It depends on nothing else.
`timescale 1ns / 1ps

package cbrh3_pkg;

    localparam int TUPLE_BITS_DEF = 16;
    localparam int NUM_HASHES_DEF = 4;
    localparam int ADDR_BITS_DEF  = 10;
    localparam int COUNT_BITS_DEF = 16;

    localparam int OPCODE_W   = 2;
    localparam int HASH_IDX_W = 2;
    localparam int BIT_IDX_W  = 4;
    localparam int THRESH_W   = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_TRAIN   = 2'd1,
        OP_PREDICT = 2'd2
    } opcode_t;

endpackage

@@ hw/rtl/cbrh3_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write of the same entry in one cycle return the old data.
`timescale 1ns / 1ps

module cbrh3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/counting_bloom_ram_h3.sv @@
// Counting Bloom filter RAM node with H3 hashes; uses cbrh3_pkg, cbrh3_ram and the
// assertion macros. A load beat writes one key word. Train and predict beats walk the
// hashes one per cycle through a key read, an address XOR and a counter read-modify-write,
// and the next train beat is taken as the last hash of the previous one issues. A predict
// beat is taken only once no other predict is in flight and the result register is free,
// so a predict waits until the previous one has left the issue stage, s1 and s2 and its
// result is no longer held. After reset the counter memory is cleared one entry a cycle,
// which holds off input beats until every entry is cleared; threshold writes are taken
// throughout.
`timescale 1ns / 1ps
`include "counting_bloom_ram_h3_assert.svh"

module counting_bloom_ram_h3 #(
    parameter int TUPLE_BITS = cbrh3_pkg::TUPLE_BITS_DEF,
    parameter int NUM_HASHES = cbrh3_pkg::NUM_HASHES_DEF,
    parameter int ADDR_BITS  = cbrh3_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS = cbrh3_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [cbrh3_pkg::THRESH_W-1:0]  cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cbrh3_pkg::OPCODE_W-1:0]  opcode,
    input  logic [TUPLE_BITS-1:0]           tuple_bits,
    input  logic [cbrh3_pkg::HASH_IDX_W-1:0] hash_index,
    input  logic [cbrh3_pkg::BIT_IDX_W-1:0] bit_index,
    input  logic [ADDR_BITS-1:0]            key_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit
);

    localparam int HW = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

    logic [cbrh3_pkg::THRESH_W-1:0] thresh_reg;

    logic                  clr_busy_reg;
    logic [ADDR_BITS-1:0]  clr_addr_reg;

    logic                  iss_busy_reg;
    logic [HW-1:0]         iss_hash_reg;
    logic                  iss_pred_reg;
    logic [TUPLE_BITS-1:0] iss_tuple_reg;

    logic                  s1_valid_reg;
    logic                  s1_pred_reg;
    logic                  s1_first_reg;
    logic                  s1_last_reg;
    logic [TUPLE_BITS-1:0] s1_tuple_reg;

    logic                  s2_valid_reg;
    logic                  s2_pred_reg;
    logic                  s2_first_reg;
    logic                  s2_last_reg;
    logic [ADDR_BITS-1:0]  s2_addr_reg;

    logic                  fw_valid_reg;
    logic [ADDR_BITS-1:0]  fw_addr_reg;
    logic [COUNT_BITS-1:0] fw_data_reg;

    logic                  hit_acc_reg;
    logic                  out_valid_reg;
    logic                  hit_reg;

    logic                  iss_last;
    logic                  is_train;
    logic                  is_pred;
    logic                  pred_in_flight;
    logic                  pred_block;
    logic                  in_accept;
    logic                  start;

    logic [ADDR_BITS-1:0]  key_rd [TUPLE_BITS];
    logic [ADDR_BITS-1:0]  hash_addr;

    logic [COUNT_BITS-1:0] cnt_rd;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  cnt_gt;
    logic                  hit_next;
    logic                  train_wr;

    logic                  cnt_we;
    logic [ADDR_BITS-1:0]  cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;

    // Input side.
    assign iss_last = (iss_hash_reg == HW'(NUM_HASHES - 1));
    assign is_train = (opcode == cbrh3_pkg::OP_TRAIN);
    assign is_pred  = (opcode == cbrh3_pkg::OP_PREDICT);

    assign pred_in_flight = (iss_busy_reg && iss_pred_reg) || (s1_valid_reg && s1_pred_reg)
                          || (s2_valid_reg && s2_pred_reg);
    // A predict may only start when its result is sure to find the register empty.
    assign pred_block = pred_in_flight || (out_valid_reg && out_stall);

    assign in_stall  = clr_busy_reg || (iss_busy_reg && !iss_last) || (is_pred && pred_block);
    assign in_accept = in_valid && !in_stall;
    assign start     = in_accept && (is_train || is_pred);

    // Key store: one RAM per tuple position, addressed by hash, so that a single read
    // returns every key word of one hash.
    generate
        for (genvar j = 0; j < TUPLE_BITS; j++)
        begin : g_key
            logic key_we;

            assign key_we = in_accept && (opcode == cbrh3_pkg::OP_LOAD)
                          && (32'(hash_index) < NUM_HASHES) && (32'(bit_index) == j);

            cbrh3_ram #(
                .WIDTH (ADDR_BITS),
                .DEPTH (NUM_HASHES)
            ) u_key_ram (
                .clk     (clk),
                .wr_en   (key_we),
                .wr_addr (HW'(hash_index)),
                .wr_data (key_value),
                .rd_en   (iss_busy_reg),
                .rd_addr (iss_hash_reg),
                .rd_data (key_rd[j])
            );
        end
    endgenerate

    always_comb
    begin
        hash_addr = '0;
        for (int j = 0; j < TUPLE_BITS; j++)
        begin
            if (s1_tuple_reg[j])
            begin
                hash_addr = hash_addr ^ key_rd[j];
            end
        end
    end

    // Counter store with the clearing pass and the training write sharing one port.
    cbrh3_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (2 ** ADDR_BITS)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_en   (s1_valid_reg),
        .rd_addr (hash_addr),
        .rd_data (cnt_rd)
    );

    // The read issued in the cycle of the previous write misses it, so that write is
    // forwarded when the addresses match.
    assign cnt_cur  = (fw_valid_reg && (fw_addr_reg == s2_addr_reg)) ? fw_data_reg : cnt_rd;
    assign cnt_inc  = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
    assign cnt_gt   = (32'(cnt_cur) > 32'(thresh_reg));
    assign hit_next = s2_first_reg ? cnt_gt : (hit_acc_reg && cnt_gt);
    assign train_wr = s2_valid_reg && !s2_pred_reg;

    assign cnt_we    = clr_busy_reg || train_wr;
    assign cnt_waddr = clr_busy_reg ? clr_addr_reg : s2_addr_reg;
    assign cnt_wdata = clr_busy_reg ? '0 : cnt_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            iss_busy_reg  <= 1'b0;
            iss_hash_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thresh_reg <= cfg_wr_data;
            end

            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
                if (clr_addr_reg == '1)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            if (start)
            begin
                iss_busy_reg <= 1'b1;
                iss_hash_reg <= '0;
            end
            else if (iss_busy_reg && iss_last)
            begin
                iss_busy_reg <= 1'b0;
            end
            else if (iss_busy_reg)
            begin
                iss_hash_reg <= iss_hash_reg + HW'(1);
            end

            s1_valid_reg <= iss_busy_reg;
            s2_valid_reg <= s1_valid_reg;
            fw_valid_reg <= train_wr;

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s2_valid_reg && s2_pred_reg && s2_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Payload of the pipeline stages.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            iss_pred_reg  <= is_pred;
            iss_tuple_reg <= tuple_bits;
        end

        s1_pred_reg  <= iss_pred_reg;
        s1_first_reg <= (iss_hash_reg == '0);
        s1_last_reg  <= iss_last;
        s1_tuple_reg <= iss_tuple_reg;

        s2_pred_reg  <= s1_pred_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_addr_reg  <= hash_addr;

        fw_addr_reg <= s2_addr_reg;
        fw_data_reg <= cnt_inc;

        if (s2_valid_reg && s2_pred_reg)
        begin
            hit_acc_reg <= hit_next;
            if (s2_last_reg)
            begin
                hit_reg <= hit_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    `CBRH3_ASSERT_NOW(a_result_slot_free, s2_valid_reg && s2_pred_reg && s2_last_reg, !out_valid_reg || !out_stall, "predict result would overwrite a held beat")
    `CBRH3_ASSERT_NOW(a_result_from_predict, $rose(out_valid_reg), $past(s2_valid_reg && s2_pred_reg && s2_last_reg), "result beat without a finished predict")
    `CBRH3_ASSERT_NOW(a_clear_alone, clr_busy_reg, !iss_busy_reg && !s1_valid_reg && !s2_valid_reg, "hash pipeline active during the clearing pass")
    `CBRH3_ASSERT_NEXT(a_forward_after_train, s2_valid_reg && s2_pred_reg, !fw_valid_reg, "forwarded data recorded for a predict")

endmodule

@@ test/counting_bloom_ram_h3_check.sv @@
// Checker for the counting Bloom filter RAM node: tracks keys, counters and threshold,
// predicts each predict answer and compares it with the result beats.
// Depends on cbrh3_pkg for the field widths and operation codes.
`timescale 1ns / 1ps

module counting_bloom_ram_h3_check #(
    parameter int TUPLE_BITS = cbrh3_pkg::TUPLE_BITS_DEF,
    parameter int NUM_HASHES = cbrh3_pkg::NUM_HASHES_DEF,
    parameter int ADDR_BITS  = cbrh3_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS = cbrh3_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cbrh3_pkg::THRESH_W-1:0]    cfg_wr_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [cbrh3_pkg::OPCODE_W-1:0]    opcode,
    input  logic [TUPLE_BITS-1:0]             tuple_bits,
    input  logic [cbrh3_pkg::HASH_IDX_W-1:0]  hash_index,
    input  logic [cbrh3_pkg::BIT_IDX_W-1:0]   bit_index,
    input  logic [ADDR_BITS-1:0]              key_value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              hit,
    input  logic                              run_done,
    output int                                pending,
    output int                                fail_count
);

    localparam int TABLE_SIZE = 1 << ADDR_BITS;

    logic [ADDR_BITS-1:0]           key_store [NUM_HASHES][TUPLE_BITS];
    logic [COUNT_BITS-1:0]          count_ram [TABLE_SIZE];
    logic [cbrh3_pkg::THRESH_W-1:0] threshold;
    logic                           hit_answers [$];
    int                             errors;
    bit                             leftovers_checked;

    // H3 hash: XOR of the key words of every set tuple position.
    function automatic logic [ADDR_BITS-1:0] h3_address(input logic [TUPLE_BITS-1:0] t,
                                                        input int h);
        logic [ADDR_BITS-1:0] acc;
        acc = '0;
        for (int j = 0; j < TUPLE_BITS; j++)
        begin
            if (t[j])
            begin
                acc ^= key_store[h][j];
            end
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [ADDR_BITS-1:0] addr;
        logic                 answer;
        logic                 wanted;
        if (!rst_n)
        begin
            threshold = '0;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                count_ram[i] = '0;
            end
            for (int h = 0; h < NUM_HASHES; h++)
            begin
                for (int j = 0; j < TUPLE_BITS; j++)
                begin
                    key_store[h][j] = '0;
                end
            end
            hit_answers.delete();
            errors = 0;
            leftovers_checked = 1'b0;
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            // Result beats are matched first: they can only belong to earlier predicts.
            if (out_valid && !out_stall)
            begin
                if (hit_answers.size() == 0)
                begin
                    $error("hit: expected no result beat, actual %0b", hit);
                    errors++;
                end
                else
                begin
                    wanted = hit_answers.pop_front();
                    if (hit !== wanted)
                    begin
                        $error("hit: expected %0b, actual %0b", wanted, hit);
                        errors++;
                    end
                end
            end

            if (cfg_wr_en)
            begin
                threshold = cfg_wr_data;
            end

            if (in_valid && !in_stall)
            begin
                case (opcode)
                    cbrh3_pkg::OP_LOAD:
                    begin
                        if (32'(hash_index) < NUM_HASHES && 32'(bit_index) < TUPLE_BITS)
                        begin
                            key_store[hash_index][bit_index] = key_value;
                        end
                    end
                    cbrh3_pkg::OP_TRAIN:
                    begin
                        for (int h = 0; h < NUM_HASHES; h++)
                        begin
                            addr = h3_address(tuple_bits, h);
                            if (count_ram[addr] != {COUNT_BITS{1'b1}})
                            begin
                                count_ram[addr] = count_ram[addr] + COUNT_BITS'(1);
                            end
                        end
                    end
                    cbrh3_pkg::OP_PREDICT:
                    begin
                        answer = 1'b1;
                        for (int h = 0; h < NUM_HASHES; h++)
                        begin
                            addr = h3_address(tuple_bits, h);
                            if (!(count_ram[addr] > threshold))
                            begin
                                answer = 1'b0;
                            end
                        end
                        hit_answers.push_back(answer);
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (run_done && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (hit_answers.size() != 0)
                begin
                    $error("hit: expected %0d more result beats, actual none",
                           hit_answers.size());
                    errors++;
                end
            end

            pending <= hit_answers.size();
            fail_count <= errors;
        end
    end

endmodule

@@ test/tb_counting_bloom_ram_h3.sv @@
// Testbench top for counting_bloom_ram_h3: clock, reset, stimulus, receiver stalls
// and the verdict. Depends on cbrh3_pkg, the block and counting_bloom_ram_h3_check.
`timescale 1ns / 1ps

module tb_counting_bloom_ram_h3;

    localparam int TUPLE_BITS = cbrh3_pkg::TUPLE_BITS_DEF;
    localparam int NUM_HASHES = cbrh3_pkg::NUM_HASHES_DEF;
    localparam int ADDR_BITS  = cbrh3_pkg::ADDR_BITS_DEF;
    localparam int OPCODE_W   = cbrh3_pkg::OPCODE_W;
    localparam int HASH_IDX_W = cbrh3_pkg::HASH_IDX_W;
    localparam int BIT_IDX_W  = cbrh3_pkg::BIT_IDX_W;
    localparam int THRESH_W   = cbrh3_pkg::THRESH_W;

    // Opcode with no operation behind it; the package has no name for it.
    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES    = 4 * NUM_HASHES;
    localparam int EMPTY_TRAINS    = 40;
    localparam int PHASE_ITEMS     = 200;
    localparam int POOL_SIZE       = 8;
    localparam int LONG_HOLD       = 600;

    typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HOLD} rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [THRESH_W-1:0]   cfg_wr_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [OPCODE_W-1:0]   opcode;
    logic [TUPLE_BITS-1:0] tuple_bits;
    logic [HASH_IDX_W-1:0] hash_index;
    logic [BIT_IDX_W-1:0]  bit_index;
    logic [ADDR_BITS-1:0]  key_value;
    logic                  out_valid;
    logic                  out_stall;
    logic                  hit;
    logic                  run_done;
    int                    pending;
    int                    fail_count;

    int unsigned           cycle_count = 0;
    int unsigned           burst_left;
    bit                    gaps_on;
    bit                    random_on;
    logic [TUPLE_BITS-1:0] tuple_pool [POOL_SIZE];

    counting_bloom_ram_h3 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .tuple_bits  (tuple_bits),
        .hash_index  (hash_index),
        .bit_index   (bit_index),
        .key_value   (key_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit)
    );

    counting_bloom_ram_h3_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .tuple_bits  (tuple_bits),
        .hash_index  (hash_index),
        .bit_index   (bit_index),
        .key_value   (key_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .run_done    (run_done),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Offers one beat and holds it until taken. Called and returns at a rising edge.
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [TUPLE_BITS-1:0] t,
                             input logic [HASH_IDX_W-1:0] hsel,
                             input logic [BIT_IDX_W-1:0] bsel,
                             input logic [ADDR_BITS-1:0] key);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        tuple_bits <= t;
        hash_index <= hsel;
        bit_index  <= bsel;
        key_value  <= key;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        if (burst_left != 0)
        begin
            burst_left--;
        end
    endtask

    // The same beat with random hash, position and key fields.
    task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [TUPLE_BITS-1:0] t);
        send_item(op, t, HASH_IDX_W'($urandom()), BIT_IDX_W'($urandom()),
                  ADDR_BITS'($urandom()));
    endtask

    // Lets every outstanding answer come back, then gives a train time to finish.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly reuses recent tuples so that predicts find trained entries.
    function automatic logic [TUPLE_BITS-1:0] pick_tuple();
        int unsigned           slot;
        logic [TUPLE_BITS-1:0] fresh;
        slot = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 99) < 65)
        begin
            return tuple_pool[slot];
        end
        case ($urandom_range(0, 3))
            0: fresh = TUPLE_BITS'($urandom() & $urandom());
            1: fresh = TUPLE_BITS'($urandom() | $urandom());
            default: fresh = TUPLE_BITS'($urandom());
        endcase
        tuple_pool[slot] = fresh;
        return fresh;
    endfunction

    initial
    begin : receiver
        rx_mode_t    mode;
        int unsigned left;
        bit          held;
        out_stall = 1'b0;
        mode = RX_FREE;
        left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                if (random_on && !held)
                begin
                    // One long hold-off, so that answers back up and the input stalls.
                    mode = RX_HOLD;
                    left = LONG_HOLD;
                    held = 1'b1;
                end
                else
                begin
                    mode = rx_mode_t'($urandom_range(0, 2));
                    left = $urandom_range(10, 150);
                end
            end
            left--;
            case (mode)
                RX_FREE:     out_stall <= 1'b0;
                RX_RANDOM:   out_stall <= ($urandom_range(0, 99) < 45);
                RX_PERIODIC: out_stall <= (cycle_count % 3 == 0);
                default:     out_stall <= 1'b1;
            endcase
        end
    end

    initial
    begin : stimulus
        logic [TUPLE_BITS-1:0] t;
        int unsigned           roll;
        int unsigned           done_items;
        logic [THRESH_W-1:0]   thresholds [5];
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        opcode      = cbrh3_pkg::OP_LOAD;
        tuple_bits  = '0;
        hash_index  = '0;
        bit_index   = '0;
        key_value   = '0;
        run_done    = 1'b0;
        gaps_on     = 1'b0;
        random_on   = 1'b0;
        burst_left  = 0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            tuple_pool[i] = TUPLE_BITS'($urandom());
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        write_threshold('0);
        gaps_on = 1'b1;

        // An empty tuple uses no key, so it may be asked before any key is loaded.
        send_op(cbrh3_pkg::OP_PREDICT, '0);
        send_item(OP_SPARE, '1, '1, '1, '1);

        for (int h = 0; h < NUM_HASHES; h++)
        begin
            for (int j = 0; j < TUPLE_BITS; j++)
            begin
                if (h == 0 && j == 0)
                begin
                    send_item(cbrh3_pkg::OP_LOAD, TUPLE_BITS'($urandom()),
                              HASH_IDX_W'(h), BIT_IDX_W'(j), '0);
                end
                else if (h == NUM_HASHES - 1 && j == TUPLE_BITS - 1)
                begin
                    send_item(cbrh3_pkg::OP_LOAD, TUPLE_BITS'($urandom()),
                              HASH_IDX_W'(h), BIT_IDX_W'(j), '1);
                end
                else
                begin
                    send_item(cbrh3_pkg::OP_LOAD, TUPLE_BITS'($urandom()),
                              HASH_IDX_W'(h), BIT_IDX_W'(j), ADDR_BITS'($urandom()));
                end
            end
        end

        send_op(cbrh3_pkg::OP_TRAIN, '1);
        send_op(cbrh3_pkg::OP_PREDICT, '1);
        send_op(cbrh3_pkg::OP_PREDICT, 16'h0001);
        send_op(cbrh3_pkg::OP_TRAIN, 16'h0001);
        send_op(cbrh3_pkg::OP_TRAIN, 16'h8000);
        send_op(cbrh3_pkg::OP_PREDICT, 16'h0001);
        send_op(cbrh3_pkg::OP_PREDICT, 16'h8000);
        send_op(cbrh3_pkg::OP_TRAIN, '0);
        send_op(cbrh3_pkg::OP_PREDICT, '0);
        send_item(cbrh3_pkg::OP_LOAD, TUPLE_BITS'($urandom()), HASH_IDX_W'(NUM_HASHES - 1),
                  BIT_IDX_W'(TUPLE_BITS - 1), 10'h155);
        send_op(cbrh3_pkg::OP_PREDICT, 16'h8000);
        send_op(cbrh3_pkg::OP_TRAIN, 16'h8000);
        send_op(cbrh3_pkg::OP_PREDICT, 16'h8000);
        send_op(OP_SPARE, TUPLE_BITS'($urandom()));

        drain();
        write_threshold('1);
        send_op(cbrh3_pkg::OP_PREDICT, '1);
        send_op(cbrh3_pkg::OP_PREDICT, '0);
        drain();
        write_threshold(16'd1);
        send_op(cbrh3_pkg::OP_PREDICT, 16'h0001);
        send_op(cbrh3_pkg::OP_PREDICT, 16'h8000);

        // The empty tuple sends every hash to entry zero, so that counter climbs
        // four steps per beat.
        drain();
        write_threshold(16'hFFFE);
        gaps_on = 1'b0;
        repeat (EMPTY_TRAINS)
        begin
            send_op(cbrh3_pkg::OP_TRAIN, '0);
        end
        gaps_on = 1'b1;
        send_op(cbrh3_pkg::OP_PREDICT, '0);
        drain();
        write_threshold('1);
        send_op(cbrh3_pkg::OP_PREDICT, '0);

        thresholds[0] = '0;
        thresholds[1] = THRESH_W'($urandom_range(1, 4));
        thresholds[2] = '1;
        thresholds[3] = THRESH_W'($urandom_range(0, 16'hFFFF));
        thresholds[4] = THRESH_W'($urandom_range(0, 2));
        random_on = 1'b1;
        foreach (thresholds[p])
        begin
            drain();
            write_threshold(thresholds[p]);
            done_items = 0;
            while (done_items < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 6)
                begin
                    send_op(cbrh3_pkg::OP_LOAD, TUPLE_BITS'($urandom()));
                    done_items++;
                end
                else if (roll < 9)
                begin
                    send_op(OP_SPARE, TUPLE_BITS'($urandom()));
                end
                else if (roll < 50)
                begin
                    t = pick_tuple();
                    send_op(cbrh3_pkg::OP_TRAIN, t);
                    done_items++;
                end
                else
                begin
                    t = pick_tuple();
                    send_op(cbrh3_pkg::OP_PREDICT, t);
                    done_items++;
                end
            end
        end

        drain();
        run_done <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/cbrh3_pkg.sv
hw/rtl/cbrh3_ram.sv
hw/rtl/counting_bloom_ram_h3.sv
test/counting_bloom_ram_h3_check.sv
test/tb_counting_bloom_ram_h3.sv
